/* src/qfp_pkg.sv */
// Shared types and constants for the quantized fader pickup block.
// No dependencies; every other file in src except qfp_ram imports this package.
package qfp_pkg;

  // Request codes carried in req_type.
  typedef enum logic [2:0] {
    REQ_SAMPLE    = 3'd0,
    REQ_READ      = 3'd1,
    REQ_LOCK      = 3'd2,
    REQ_SET       = 3'd3,
    REQ_UNLOCK    = 3'd4,
    REQ_OVERWRITE = 3'd5
  } qfp_req_e;

  // Pickup (soft takeover) state.
  typedef enum logic [1:0] {
    LK_LOCKED     = 2'd0,
    LK_UNLOCK_REQ = 2'd1,
    LK_UNLOCKED   = 2'd2
  } qfp_lock_e;

  // Sequencer states of the top level.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_DRAIN,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_MAP_GO,
    ST_MAP_WAIT,
    ST_FINISH
  } qfp_state_e;

  // Configuration register indexes (byte address bits [3:2]).
  localparam logic [1:0] REG_AVG_LEN    = 2'd0;
  localparam logic [1:0] REG_FULL_SCALE = 2'd1;
  localparam logic [1:0] REG_RANGE_LOW  = 2'd2;
  localparam logic [1:0] REG_RANGE_HIGH = 2'd3;

  localparam int CTRL_W = 16;  // control value width
  localparam int SPAN_W = 17;  // magnitude of range_high + 1 - range_low
  localparam int DEN_W  = 13;  // divisor width: adc_full_scale + 1, or averaged count

  // Status of a serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } qfp_unit_sts_t;

endpackage

/* src/qfp_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module qfp_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/qfp_serdiv.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on qfp_pkg for the unit status struct.
module qfp_serdiv #(
  parameter int NUM_W = 29,
  parameter int DEN_W = 13
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [NUM_W-1:0]      num_i,
  input  logic [DEN_W-1:0]      den_i,
  output logic [NUM_W-1:0]      quot_o,
  output qfp_pkg::qfp_unit_sts_t sts_o
);
  import qfp_pkg::*;

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             qbit;

  // Shift the next numerator bit into the partial remainder and try a subtract.
  always_comb begin
    rem_sh  = {rem_q, quo_q[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    qbit    = (rem_sh >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], qbit};
      rem_q <= qbit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign quot_o     = quo_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

/* src/qfp_sermul.sv */
// Bit-serial shift-add multiplier: one bit of the A operand per cycle.
// Depends on qfp_pkg for the unit status struct.
module qfp_sermul #(
  parameter int A_W = 12,
  parameter int B_W = 17
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [A_W-1:0]         a_i,
  input  logic [B_W-1:0]         b_i,
  output logic [A_W+B_W-1:0]     prod_o,
  output qfp_pkg::qfp_unit_sts_t sts_o
);
  import qfp_pkg::*;

  localparam int PW = A_W + B_W;
  localparam int CW = $clog2(A_W + 1);

  logic [PW-1:0] p_q;
  logic [B_W-1:0] b_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [B_W:0]  hi_sum;

  // The upper half accumulates the B operand; the word then shifts right one place.
  assign hi_sum = {1'b0, p_q[PW-1:A_W]} + (p_q[0] ? {1'b0, b_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(A_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p_q <= {{B_W{1'b0}}, a_i};
      b_q <= b_i;
    end else if (busy_q) begin
      p_q <= {hi_sum, p_q[A_W-1:1]};
    end
  end

  assign prod_o     = p_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

/* src/quantized_fader_pickup.sv */
// Top level of the quantized fader pickup: sample ring, serial mean and map, lock logic.
// Depends on qfp_pkg, qfp_ram, qfp_serdiv and qfp_sermul.
//
//   Channel   Handshake                 Payload
//   input     in_valid_i / in_stall_o   req_type_i, sample_i, jam_value_i
//   output    out_valid_o / out_stall_i ctrl_value_o, lock_state_o, measured_slice_o,
//                                       ready_res_o
//   config    APB psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// A sample request yields no result. Requests 1 to 5 sum the n averaged entries, n being
// the averaged count (1 before the ring is ready), divide by n, multiply by the span and
// divide by full scale + 1; the two passes of the bit-serial divider take most of the time.
// The ring is read one entry per cycle through the RAM read port. Reset clears the ring
// through per-entry valid bits, so no clearing pass is needed. A finished result waits in
// the output register while out_stall_i is high; a new request is still taken meanwhile.
module quantized_fader_pickup #(
  parameter int RING_DEPTH  = 16,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // request channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [2:0]             req_type_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [15:0]     jam_value_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [15:0]     ctrl_value_o,
  output logic [1:0]             lock_state_o,
  output logic signed [15:0]     measured_slice_o,
  output logic                   ready_res_o,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import qfp_pkg::*;

  localparam int AW    = $clog2(RING_DEPTH);
  localparam int SUM_W = SAMPLE_BITS + AW;
  localparam int NUM_W = SAMPLE_BITS + SPAN_W;

  // Configuration registers.
  logic [3:0]         avg_len_q;
  logic [11:0]        full_scale_q;
  logic signed [15:0] range_low_q;
  logic signed [15:0] range_high_q;

  // Architectural state.
  logic [AW-1:0]         write_idx_q;
  logic                  ring_ready_q;
  logic [RING_DEPTH-1:0] valid_q;
  logic signed [15:0]    held_q;
  qfp_lock_e             pstate_q;

  // Request working registers.
  qfp_state_e         state_q, state_d;
  qfp_req_e           req_q;
  logic signed [15:0] jam_q;
  logic [AW-1:0]      n_q;
  logic [AW-1:0]      rd_cnt_q;
  logic               issue_q;
  logic               rd_valid_q;
  logic [SUM_W-1:0]   sum_q;
  logic               neg_q;

  // Output register.
  logic               out_valid_q;
  logic signed [15:0] out_ctrl_q;
  qfp_lock_e          out_lock_q;
  logic signed [15:0] out_slice_q;
  logic               out_ready_q;

  logic                    in_accept;
  logic                    out_accept;
  logic                    cfg_write;
  logic                    start_req;
  logic                    ram_we;
  logic [SAMPLE_BITS-1:0]  ram_rdata;
  logic [AW-1:0]           eff_len;
  logic [AW:0]             next_idx;
  logic                    idx_wrap;
  logic                    div_start;
  logic                    mul_start;
  logic                    out_load;
  logic [NUM_W-1:0]        div_num;
  logic [DEN_W-1:0]        div_den;
  logic [NUM_W-1:0]        div_quot;
  qfp_unit_sts_t           div_sts;
  logic [NUM_W-1:0]        mul_prod;
  qfp_unit_sts_t           mul_sts;
  logic signed [17:0]      span_c;
  logic [SPAN_W-1:0]       span_mag;
  logic [15:0]             quot_lo;
  logic signed [15:0]      slice_c;
  qfp_lock_e               p_mid;
  logic signed [15:0]      h_mid;
  qfp_lock_e               p_rd;
  logic signed [15:0]      rd_ans;
  qfp_lock_e               p_new;
  logic signed [15:0]      h_new;
  logic signed [15:0]      ctrl_new;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_q && !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign start_req  = in_accept && (req_type_i inside {[REQ_READ:REQ_OVERWRITE]});
  assign ram_we     = in_accept && (req_type_i == REQ_SAMPLE);
  assign cfg_write  = psel && penable && pwrite;
  assign pready     = 1'b1;

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_len_q    <= 4'd15;
      full_scale_q <= 12'd4095;
      range_low_q  <= 16'sd0;
      range_high_q <= 16'sd12;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_AVG_LEN:    avg_len_q    <= pwdata[3:0];
        REG_FULL_SCALE: full_scale_q <= pwdata[11:0];
        REG_RANGE_LOW:  range_low_q  <= pwdata[15:0];
        REG_RANGE_HIGH: range_high_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_AVG_LEN:    prdata = {28'b0, avg_len_q};
      REG_FULL_SCALE: prdata = {20'b0, full_scale_q};
      REG_RANGE_LOW:  prdata = {16'b0, range_low_q};
      REG_RANGE_HIGH: prdata = {16'b0, range_high_q};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- sample ring
  // Averaged length is clamped to 1 .. RING_DEPTH-1.
  always_comb begin
    if (avg_len_q == 4'd0) begin
      eff_len = AW'(1);
    end else if ({28'b0, avg_len_q} > 32'(RING_DEPTH - 1)) begin
      eff_len = AW'(RING_DEPTH - 1);
    end else begin
      eff_len = AW'(avg_len_q);
    end
    next_idx = {1'b0, write_idx_q} + 1'b1;
    idx_wrap = (next_idx >= {1'b0, eff_len});
  end

  qfp_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (write_idx_q),
    .wdata_i (sample_i),
    .raddr_i (rd_cnt_q),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- serial units
  always_comb begin
    if (state_q == ST_MEAN_GO) begin
      div_num = NUM_W'(sum_q);
      div_den = DEN_W'(n_q);
    end else begin
      div_num = mul_prod;
      div_den = {1'b0, full_scale_q} + 13'd1;
    end
    span_c   = 18'(range_high_q) + 18'sd1 - 18'(range_low_q);
    span_mag = span_c[17] ? SPAN_W'(-span_c) : SPAN_W'(span_c);
  end

  qfp_serdiv #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quot_o  (div_quot),
    .sts_o   (div_sts)
  );

  qfp_sermul #(
    .A_W (SAMPLE_BITS),
    .B_W (SPAN_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (div_quot[SAMPLE_BITS-1:0]),
    .b_i     (span_mag),
    .prod_o  (mul_prod),
    .sts_o   (mul_sts)
  );

  // The quotient magnitude is reapplied with the span's sign; only 16 bits survive.
  assign quot_lo = div_quot[15:0];
  assign slice_c = 16'((neg_q ? (16'd0 - quot_lo) : quot_lo) + range_low_q);

  // ---------------------------------------------------------------- lock logic
  always_comb begin
    p_mid = pstate_q;
    h_mid = held_q;
    if (req_q == REQ_UNLOCK && pstate_q == LK_LOCKED) begin
      p_mid = LK_UNLOCK_REQ;
    end
    if (req_q == REQ_OVERWRITE) begin
      h_mid = slice_c;
    end

    p_rd   = p_mid;
    rd_ans = h_mid;
    if (p_mid != LK_LOCKED && ring_ready_q) begin
      if (p_mid == LK_UNLOCKED) begin
        rd_ans = slice_c;
      end else if (slice_c == h_mid) begin
        p_rd   = LK_UNLOCKED;
        rd_ans = slice_c;
      end
    end

    p_new    = p_rd;
    h_new    = held_q;
    ctrl_new = rd_ans;
    case (req_q)
      REQ_LOCK: begin
        p_new = LK_LOCKED;
        h_new = rd_ans;
      end
      REQ_SET: begin
        p_new    = pstate_q;
        h_new    = jam_q;
        ctrl_new = jam_q;
      end
      REQ_OVERWRITE: begin
        h_new    = slice_c;
        ctrl_new = slice_c;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    mul_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_req) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        if (rd_cnt_q == n_q - 1'b1) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_MEAN_GO;
      ST_MEAN_GO: begin
        div_start = 1'b1;
        state_d   = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (div_sts.done) begin
          state_d = ST_MUL_GO;
        end
      end
      ST_MUL_GO: begin
        mul_start = 1'b1;
        state_d   = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (mul_sts.done) begin
          state_d = ST_MAP_GO;
        end
      end
      ST_MAP_GO: begin
        div_start = 1'b1;
        state_d   = ST_MAP_WAIT;
      end
      ST_MAP_WAIT: begin
        if (div_sts.done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_idx_q  <= '0;
      ring_ready_q <= 1'b0;
      valid_q      <= '0;
      held_q       <= 16'sd0;
      pstate_q     <= LK_LOCKED;
      issue_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      issue_q <= (state_q == ST_SUM);
      if (ram_we) begin
        valid_q[write_idx_q] <= 1'b1;
        if (idx_wrap) begin
          write_idx_q  <= '0;
          ring_ready_q <= 1'b1;
        end else begin
          write_idx_q <= next_idx[AW-1:0];
        end
      end
      if (out_load) begin
        held_q      <= h_new;
        pstate_q    <= p_new;
        out_valid_q <= 1'b1;
      end else if (out_accept) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    rd_valid_q <= valid_q[rd_cnt_q];
    if (start_req) begin
      req_q    <= qfp_req_e'(req_type_i);
      jam_q    <= jam_value_i;
      n_q      <= ring_ready_q ? eff_len : AW'(1);
      rd_cnt_q <= '0;
      sum_q    <= '0;
    end else begin
      if (state_q == ST_SUM) begin
        rd_cnt_q <= rd_cnt_q + 1'b1;
      end
      // Entries never written since reset read as zero.
      if (issue_q && rd_valid_q) begin
        sum_q <= sum_q + SUM_W'(ram_rdata);
      end
    end
    if (mul_start) begin
      neg_q <= span_c[17];
    end
    if (out_load) begin
      out_ctrl_q  <= ctrl_new;
      out_lock_q  <= p_new;
      out_slice_q <= slice_c;
      out_ready_q <= ring_ready_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign ctrl_value_o     = out_ctrl_q;
  assign lock_state_o     = out_lock_q;
  assign measured_slice_o = out_slice_q;
  assign ready_res_o      = out_ready_q;

  // ---------------------------------------------------------------- assertions
  a_units_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_sts.busy && mul_sts.busy))
    else $error("divider and multiplier busy at the same time");

  a_ready_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(ring_ready_q))
    else $error("ring ready flag cleared");

  a_finish_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && (!out_valid_q || !out_stall_i)) |=>
      (out_valid_q && state_q == ST_IDLE))
    else $error("finished request not presented on the output");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for quantized_fader_pickup: sample ring, mapped slice and pickup logic.
// Depends on qfp_pkg and the RTL top; requests are predicted in-line and results are checked
// in order, with random idling on both channels and register changes between phases.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import qfp_pkg::*;

  localparam int RING_DEPTH    = 16;
  localparam int SAMPLE_BITS   = 12;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES   = 600;
  localparam int HOLD_AT       = 300;

  // Request codes the block must ignore.
  localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

  typedef struct {
    logic [2:0]               kind;
    logic [SAMPLE_BITS-1:0]   smp;
    logic signed [15:0]       jam;
  } fader_req_t;

  typedef struct {
    logic signed [15:0] ctrl;
    logic [1:0]         lstate;
    logic signed [15:0] slice;
    logic               rdy;
  } pickup_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_stall_o;
  logic [2:0]             req_type = REQ_SAMPLE;
  logic [SAMPLE_BITS-1:0] sample = '0;
  logic signed [15:0]     jam_value = '0;
  logic                   out_valid_o;
  logic                   out_stall = 1'b0;
  logic signed [15:0]     ctrl_value_o;
  logic [1:0]             lock_state_o;
  logic signed [15:0]     measured_slice_o;
  logic                   ready_res_o;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [3:0]             paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;

  quantized_fader_pickup #(
    .RING_DEPTH (RING_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type),
    .sample_i        (sample),
    .jam_value_i     (jam_value),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .ctrl_value_o    (ctrl_value_o),
    .lock_state_o    (lock_state_o),
    .measured_slice_o(measured_slice_o),
    .ready_res_o     (ready_res_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #2 clk_i = ~clk_i;

  // Predicted block state and register copy.
  logic [SAMPLE_BITS-1:0] ring_m [RING_DEPTH] = '{default: '0};
  logic [3:0]             widx_m = '0;
  logic                   ready_m = 1'b0;
  logic signed [15:0]     held_m = '0;
  qfp_lock_e              pstate_m = LK_LOCKED;
  logic [3:0]             cfg_avg = 4'd15;
  logic [11:0]            cfg_fs = 12'd4095;
  logic signed [15:0]     cfg_lo = 16'sd0;
  logic signed [15:0]     cfg_hi = 16'sd12;

  fader_req_t     req_queue [$];
  pickup_result_t result_queue [$];
  fader_req_t     next_req;
  pickup_result_t got_exp;

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned n_taken = 0;
  int unsigned n_samples = 0;
  int unsigned n_results = 0;
  int unsigned n_pickups = 0;
  int unsigned n_settings = 1;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          calm = 1'b0;

  function automatic int avg_count();
    int n;
    n = int'(cfg_avg);
    if (n < 1) n = 1;
    if (n > RING_DEPTH - 1) n = RING_DEPTH - 1;
    return n;
  endfunction

  // Truncated mean of the ring (entry 0 before the first fill), mapped onto the range.
  function automatic logic signed [15:0] mapped_slice();
    longint sum, mean, span, den, q;
    int i, n;
    n = avg_count();
    if (!ready_m) begin
      mean = longint'(ring_m[0]);
    end else begin
      sum = 0;
      for (i = 0; i < n; i++) sum += longint'(ring_m[i]);
      mean = sum / longint'(n);
    end
    span = longint'(cfg_hi) + 1 - longint'(cfg_lo);
    den = longint'(cfg_fs) + 1;
    q = (mean * span) / den + longint'(cfg_lo);
    return q[15:0];
  endfunction

  function automatic logic signed [15:0] read_answer();
    logic signed [15:0] s;
    if (pstate_m == LK_LOCKED || !ready_m) return held_m;
    s = mapped_slice();
    if (pstate_m == LK_UNLOCKED) return s;
    if (s == held_m) begin
      pstate_m = LK_UNLOCKED;
      n_pickups++;
      return s;
    end
    return held_m;
  endfunction

  function automatic logic signed [15:0] request_unlock();
    if (pstate_m == LK_LOCKED) pstate_m = LK_UNLOCK_REQ;
    return read_answer();
  endfunction

  function automatic void apply_request(logic [2:0] kind, logic [SAMPLE_BITS-1:0] smp,
                                        logic signed [15:0] jam);
    pickup_result_t r;
    qfp_lock_e was;
    n_taken++;
    case (kind)
      REQ_SAMPLE: begin
        n_samples++;
        ring_m[widx_m] = smp;
        // Also covers an index left beyond a shrunken average length.
        if (int'(widx_m) + 1 >= avg_count()) begin
          widx_m = '0;
          ready_m = 1'b1;
        end else begin
          widx_m = widx_m + 4'd1;
        end
        return;
      end
      REQ_READ:   r.ctrl = read_answer();
      REQ_LOCK: begin
        held_m = read_answer();
        pstate_m = LK_LOCKED;
        r.ctrl = held_m;
      end
      REQ_SET: begin
        held_m = jam;
        r.ctrl = held_m;
      end
      REQ_UNLOCK: r.ctrl = request_unlock();
      REQ_OVERWRITE: begin
        was = pstate_m;
        held_m = mapped_slice();
        if (was != LK_LOCKED) void'(request_unlock());
        r.ctrl = held_m;
      end
      default: return;
    endcase
    r.lstate = pstate_m;
    r.slice = mapped_slice();
    r.rdy = ready_m;
    result_queue = {result_queue, r};
  endfunction

  function automatic void check_field(string what, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
      errors++;
    end
  endfunction

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) apply_request(req_type, sample, jam_value);
      if (!in_valid || !in_stall_o) begin
        if (req_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 9)) begin
          next_req = req_queue.pop_front();
          in_valid <= 1'b1;
          req_type <= next_req.kind;
          sample <= next_req.smp;
          jam_value <= next_req.jam;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Once, the receiver holds off long enough for the block to back up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (result_queue.size() == 0) begin
          $display("%0t: result with nothing expected, ctrl_value %0d", $time, ctrl_value_o);
          errors++;
        end else begin
          got_exp = result_queue.pop_front();
          check_field("ctrl_value", int'(got_exp.ctrl), int'(ctrl_value_o));
          check_field("lock_state", int'(got_exp.lstate), int'(lock_state_o));
          check_field("measured_slice", int'(got_exp.slice), int'(measured_slice_o));
          check_field("ready_res", int'(got_exp.rdy), int'(ready_res_o));
        end
        n_results++;
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && n_results >= HOLD_AT) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && $urandom_range(0, 99) < 9;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    logic [31:0] got, mask;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_AVG_LEN:    begin cfg_avg = val[3:0];   mask = 32'h0000_000F; end
      REG_FULL_SCALE: begin cfg_fs = val[11:0];   mask = 32'h0000_0FFF; end
      REG_RANGE_LOW:  begin cfg_lo = val[15:0];   mask = 32'h0000_FFFF; end
      default:        begin cfg_hi = val[15:0];   mask = 32'h0000_FFFF; end
    endcase
    // Read the register back.
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if ((got & mask) !== (val & mask)) begin
      $display("%0t: register %0d readback, expected %0h, got %0h", $time, idx, val & mask,
               got & mask);
      errors++;
    end
  endtask

  function automatic void queue_request(logic [2:0] kind, logic [SAMPLE_BITS-1:0] smp,
                                        logic signed [15:0] jam);
    fader_req_t q;
    q.kind = kind;
    q.smp = smp;
    q.jam = jam;
    req_queue = {req_queue, q};
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
  endfunction

  // Lock values often land inside the range so that pickups happen.
  function automatic logic signed [15:0] pick_jam();
    int r, lo, hi;
    r = $urandom_range(0, 99);
    lo = int'(cfg_lo);
    hi = int'(cfg_hi);
    if (r < 3) return 16'sh8000;
    if (r < 6) return 16'sh7FFF;
    if (r < 50 && lo <= hi) return 16'(lo + int'($urandom_range(0, hi - lo)));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic void queue_random_requests(int unsigned n);
    int unsigned i, r;
    logic [2:0] kind;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) kind = REQ_SAMPLE;
      else if (r < 65) kind = REQ_READ;
      else if (r < 73) kind = REQ_LOCK;
      else if (r < 81) kind = REQ_SET;
      else if (r < 91) kind = REQ_UNLOCK;
      else if (r < 98) kind = REQ_OVERWRITE;
      else kind = $urandom_range(0, 1) ? REQ_UNUSED_HI : REQ_UNUSED_LO;
      queue_request(kind, pick_sample(), pick_jam());
    end
  endfunction

  // The sender pauses here until every expected result has arrived.
  task automatic wait_drained();
    do @(posedge clk_i); while (req_queue.size() != 0 || in_valid || result_queue.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [3:0] avg, logic [11:0] fs, logic signed [15:0] lo,
                           logic signed [15:0] hi, int unsigned n);
    reg_write(REG_AVG_LEN, {28'd0, avg});
    reg_write(REG_FULL_SCALE, {20'd0, fs});
    reg_write(REG_RANGE_LOW, {16'd0, lo});
    reg_write(REG_RANGE_HIGH, {16'd0, hi});
    n_settings++;
    queue_random_requests(n);
    wait_drained();
  endtask

  initial begin
    int k, lo;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at reset settings: requests before the ring is ready, lock value
    // extremes, the first fill, an unlock that picks up through overwrite, ignored codes.
    queue_request(REQ_READ, SAMPLE_BITS'($urandom), 16'($urandom));
    queue_request(REQ_UNLOCK, SAMPLE_BITS'($urandom), 16'($urandom));
    queue_request(REQ_OVERWRITE, SAMPLE_BITS'($urandom), 16'($urandom));
    queue_request(REQ_SET, SAMPLE_BITS'($urandom), 16'sh7FFF);
    queue_request(REQ_SET, SAMPLE_BITS'($urandom), 16'sh8000);
    queue_request(REQ_LOCK, SAMPLE_BITS'($urandom), 16'($urandom));
    queue_request(REQ_SAMPLE, '1, 16'($urandom));
    queue_request(REQ_READ, SAMPLE_BITS'($urandom), 16'($urandom));
    for (k = 1; k < 15; k++) queue_request(REQ_SAMPLE, (k % 2) ? '0 : '1, 16'($urandom));
    queue_request(REQ_UNLOCK, SAMPLE_BITS'($urandom), 16'($urandom));
    queue_request(REQ_OVERWRITE, SAMPLE_BITS'($urandom), 16'($urandom));
    queue_request(REQ_READ, SAMPLE_BITS'($urandom), 16'($urandom));
    queue_request(REQ_LOCK, SAMPLE_BITS'($urandom), 16'($urandom));
    queue_request(REQ_UNUSED_LO, SAMPLE_BITS'($urandom), 16'($urandom));
    queue_request(REQ_UNUSED_HI, SAMPLE_BITS'($urandom), 16'($urandom));
    wait_drained();

    calm = 1'b1;
    run_phase(4'd4, 12'd4095, 16'sd0, 16'sd12, 300);
    calm = 1'b0;
    run_phase(4'd1, 12'd255, -16'sd3, 16'sd3, 250);
    run_phase(4'd15, 12'd4095, 16'sh8000, 16'sh7FFF, 250);
    // Zero average length, full scale of one and an inverted range.
    run_phase(4'd0, 12'd1, 16'sd5, 16'sd2, 200);
    run_phase(4'd7, 12'd4095, 16'sh7FFF, 16'sh8000, 200);
    run_phase(4'd2, 12'd100, 16'sd0, 16'sd12, 250);
    run_phase(4'd9, 12'd0, -16'sd10, 16'sd10, 200);
    for (k = 0; k < 2; k++) begin
      lo = int'($urandom_range(0, 200)) - 100;
      run_phase(4'($urandom_range(0, 15)), 12'($urandom_range(1, 4095)), 16'(lo),
                16'(lo + int'($urandom_range(0, 24))), 200);
    end

    $display("tb_top: %0d requests taken (%0d samples), %0d results checked", n_taken,
             n_samples, n_results);
    $display("tb_top: %0d pickups seen over %0d register settings", n_pickups, n_settings);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
